// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that also holds while reset is high
`define SXL_ASSERT(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("sxl port check failed");

// check that is switched off while reset is high
`define SXL_ASSERT_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sxl port check failed");

`endif

// ===== sv/sxl_pkg.sv =====
package sxl_pkg;

   localparam int FRAC_BITS   = 12;
   localparam int LOGIT_W     = 16;
   localparam int LABEL_W     = 13;
   localparam int LEN_W       = 13;
   localparam int LOSS_W      = 16;
   localparam int SUM_W       = 32;
   localparam int TERM_W      = 20;
   localparam int SP_ENTRIES  = 256;
   localparam int SP_W        = 12;
   localparam int SP_IDX_W    = $clog2(SP_ENTRIES);
   localparam int SP_SHIFT    = FRAC_BITS + 3 - SP_IDX_W;
   localparam int SP_LIMIT    = 8 << FRAC_BITS;
   localparam int DIV_STEPS   = SUM_W;
   localparam int STEP_W      = $clog2(DIV_STEPS);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int SERIES_TERMS = 24;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic [LOSS_W-1:0] LOSS_MAX = {1'b0, {(LOSS_W-1){1'b1}}};
   localparam logic [LOSS_W-1:0] LOSS_MIN = {1'b1, {(LOSS_W-1){1'b0}}};

   localparam logic [63:0] Q32_ONE     = 64'd1 << 32;
   localparam logic [63:0] SP_HALF_BIN = (64'd4 << 32) / SP_ENTRIES;

   typedef struct packed {
      logic signed [SUM_W-1:0] sum;
      logic [LEN_W-1:0]        len;
   } row_entry_type;

   typedef logic [SP_W-1:0] sp_rom_type [SP_ENTRIES];

   // long division, only used while the softplus table is built
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // exp(-v), v in Q32, v <= 0.5
   function automatic logic [63:0] exp_neg_q32(input logic [63:0] v);
      logic [63:0] acc;
      logic [63:0] term;
      acc  = Q32_ONE;
      term = Q32_ONE;
      for (int k = 1; k <= SERIES_TERMS; k++) begin
         term = udiv64((term * v) >> 32, 64'(k));
         if ((k & 1) != 0)
            acc = acc - term;
         else
            acc = acc + term;
      end
      return acc;
   endfunction

   // ln(1+u), u in Q32, 0 < u < 1
   function automatic logic [63:0] ln1p_q32(input logic [63:0] u);
      logic [63:0] z;
      logic [63:0] z2;
      logic [63:0] term;
      logic [63:0] acc;
      z    = udiv64(u << 32, (64'd2 << 32) + u);
      z2   = (z * z) >> 32;
      term = z;
      acc  = '0;
      for (int k = 0; k < SERIES_TERMS; k++) begin
         acc  = acc + udiv64(term, 64'(2 * k + 1));
         term = (term * z2) >> 32;
      end
      return acc << 1;
   endfunction

   // softplus(-|x|) at each bin midpoint, rounded to Q.FRAC_BITS
   function automatic sp_rom_type sp_rom_build();
      sp_rom_type  rom;
      logic [63:0] step;
      logic [63:0] u;
      logic [63:0] r;
      step = exp_neg_q32(SP_HALF_BIN << 1);
      u    = exp_neg_q32(SP_HALF_BIN);
      for (int k = 0; k < SP_ENTRIES; k++) begin
         r      = ln1p_q32(u);
         rom[k] = SP_W'((r + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
         u      = (u * step) >> 32;
      end
      return rom;
   endfunction

   localparam sp_rom_type SP_ROM = sp_rom_build();

endpackage

// ===== sv/sxl_front.sv =====
module sxl_front #(
   parameter int ROW_MAX = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic signed [sxl_pkg::LOGIT_W-1:0]  req_logit,
   input  logic [sxl_pkg::LABEL_W-1:0]         req_label,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sxl_pkg::LEN_W-1:0]           csr_row_length,
   output logic                                q_push,
   output sxl_pkg::row_entry_type              q_data,
   input  logic                                q_full
);

   localparam int PROD_W = sxl_pkg::LOGIT_W + sxl_pkg::LABEL_W + 1;
   localparam int ACC_W  = sxl_pkg::SUM_W + 2;

   logic signed [PROD_W-1:0]             prod_full;
   logic signed [PROD_W:0]               prod_rnd;
   logic signed [PROD_W-sxl_pkg::FRAC_BITS:0] prod_q;
   logic [sxl_pkg::LOGIT_W-1:0]          relu;
   logic [sxl_pkg::LOGIT_W-1:0]          mag;
   logic [sxl_pkg::SP_W-1:0]             sp;
   logic signed [sxl_pkg::TERM_W-1:0]    term_in;
   logic signed [sxl_pkg::TERM_W-1:0]    term_ff;

   logic                                 s1_valid_ff, s1_valid_in;
   logic signed [sxl_pkg::SUM_W-1:0]     row_sum_ff, row_sum_in;
   logic [sxl_pkg::LEN_W-1:0]            count_ff, count_in;
   logic [sxl_pkg::LEN_W-1:0]            csr_len_ff, csr_len_in;

   logic signed [ACC_W-1:0]              acc_sum;
   logic signed [sxl_pkg::SUM_W-1:0]     sum_sat;
   logic [sxl_pkg::LEN_W-1:0]            len_eff;
   logic [sxl_pkg::LEN_W:0]              count_next;
   logic                                 row_end;
   logic                                 stall;
   logic                                 accept;

   // stage 1: product, relu and softplus lookup
   always_comb begin
      prod_full = req_logit * $signed({1'b0, req_label});
      prod_rnd  = (PROD_W+1)'(prod_full) + ((PROD_W+1)'(1) <<< (sxl_pkg::FRAC_BITS - 1));
      prod_q    = prod_rnd[PROD_W:sxl_pkg::FRAC_BITS];
      relu      = (!req_logit[sxl_pkg::LOGIT_W-1] && (req_logit != '0)) ? req_logit : '0;
      mag       = req_logit[sxl_pkg::LOGIT_W-1] ? (~req_logit + 1'b1) : req_logit;
      if (32'(mag) < sxl_pkg::SP_LIMIT)
         sp = sxl_pkg::SP_ROM[sxl_pkg::SP_IDX_W'(mag >> sxl_pkg::SP_SHIFT)];
      else
         sp = '0;
      term_in = sxl_pkg::TERM_W'(prod_q) - sxl_pkg::TERM_W'({1'b0, relu})
                - sxl_pkg::TERM_W'({1'b0, sp});
   end

   // stage 2: saturating accumulate and row end
   always_comb begin
      acc_sum = ACC_W'(row_sum_ff) + ACC_W'(term_ff);
      if ((acc_sum[ACC_W-1:sxl_pkg::SUM_W-1] != '0)
          && (acc_sum[ACC_W-1:sxl_pkg::SUM_W-1] != '1))
         sum_sat = acc_sum[ACC_W-1] ? sxl_pkg::SUM_MIN : sxl_pkg::SUM_MAX;
      else
         sum_sat = acc_sum[sxl_pkg::SUM_W-1:0];

      priority if (csr_len_ff == '0)
         len_eff = sxl_pkg::LEN_W'(1);
      else if (32'(csr_len_ff) > ROW_MAX)
         len_eff = sxl_pkg::LEN_W'(ROW_MAX);
      else
         len_eff = csr_len_ff;

      count_next = {1'b0, count_ff} + 1'b1;
      row_end    = count_next >= {1'b0, len_eff};
      stall      = s1_valid_ff && row_end && q_full;
      accept     = req_push && !stall;

      q_push     = s1_valid_ff && row_end && !q_full;
      q_data.sum = sum_sat;
      q_data.len = len_eff;

      s1_valid_in = accept || stall;
      row_sum_in  = row_sum_ff;
      count_in    = count_ff;
      if (s1_valid_ff && !stall) begin
         if (row_end) begin
            row_sum_in = '0;
            count_in   = '0;
         end else begin
            row_sum_in = sum_sat;
            count_in   = count_next[sxl_pkg::LEN_W-1:0];
         end
      end
      csr_len_in = csr_valid ? csr_row_length : csr_len_ff;
   end

   assign req_full  = stall;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         row_sum_ff  <= '0;
         count_ff    <= '0;
         csr_len_ff  <= sxl_pkg::LEN_W'(1);
      end else begin
         s1_valid_ff <= s1_valid_in;
         row_sum_ff  <= row_sum_in;
         count_ff    <= count_in;
         csr_len_ff  <= csr_len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         term_ff <= term_in;
      end
   end

endmodule

// ===== sv/sxl_queue.sv =====
module sxl_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  sxl_pkg::row_entry_type push_data,
   output logic                   full,
   input  logic                   pop,
   output sxl_pkg::row_entry_type pop_data,
   output logic                   empty
);

   sxl_pkg::row_entry_type mem [sxl_pkg::QUEUE_DEPTH];

   logic [sxl_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [sxl_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [sxl_pkg::QPTR_W:0]   fill_ff, fill_in;
   logic                       do_push;
   logic                       do_pop;

   always_comb begin
      full     = fill_ff == (sxl_pkg::QPTR_W+1)'(sxl_pkg::QUEUE_DEPTH);
      empty    = fill_ff == '0;
      do_push  = push && !full;
      do_pop   = pop && !empty;
      pop_data = mem[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == sxl_pkg::QPTR_W'(sxl_pkg::QUEUE_DEPTH - 1)) ? '0
                     : wr_ptr_ff + 1'b1;
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == sxl_pkg::QPTR_W'(sxl_pkg::QUEUE_DEPTH - 1)) ? '0
                     : rd_ptr_ff + 1'b1;

      unique case ({do_push, do_pop})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/sxl_back.sv =====
module sxl_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_empty,
   input  sxl_pkg::row_entry_type             q_data,
   output logic                               q_pop,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic signed [sxl_pkg::LOSS_W-1:0]  rsp_row_loss,
   output logic                               rsp_saturated
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_HOLD
   } state_type;

   state_type                    state_ff;
   logic                         out_valid_ff;
   logic [sxl_pkg::LOSS_W-1:0]   out_loss_ff;
   logic                         out_sat_ff;

   logic [sxl_pkg::SUM_W-1:0]    num_ff;
   logic [sxl_pkg::SUM_W-1:0]    quo_ff;
   logic [sxl_pkg::LEN_W-1:0]    rem_ff;
   logic [sxl_pkg::LEN_W-1:0]    den_ff;
   logic [sxl_pkg::STEP_W-1:0]   step_ff;
   logic                         neg_ff;

   logic [sxl_pkg::SUM_W-1:0]    abs_sum;
   logic [sxl_pkg::SUM_W-1:0]    num_in;
   logic                         neg_in;
   logic [sxl_pkg::LEN_W:0]      rem_sh;
   logic [sxl_pkg::LEN_W-1:0]    rem_in;
   logic                         qbit;
   logic [sxl_pkg::LOSS_W-1:0]   res_loss;
   logic                         res_sat;
   logic                         out_free;

   always_comb begin
      // mean is -sum/n, so a positive sum gives a negative loss
      abs_sum = q_data.sum[sxl_pkg::SUM_W-1] ? (~q_data.sum + 1'b1) : q_data.sum;
      num_in  = abs_sum + sxl_pkg::SUM_W'(q_data.len >> 1);
      neg_in  = !q_data.sum[sxl_pkg::SUM_W-1] && (q_data.sum != '0);

      rem_sh = {rem_ff, num_ff[sxl_pkg::SUM_W-1]};
      if (rem_sh >= {1'b0, den_ff}) begin
         rem_in = sxl_pkg::LEN_W'(rem_sh - {1'b0, den_ff});
         qbit   = 1'b1;
      end else begin
         rem_in = rem_sh[sxl_pkg::LEN_W-1:0];
         qbit   = 1'b0;
      end

      if (neg_ff) begin
         if (quo_ff > sxl_pkg::SUM_W'(sxl_pkg::LOSS_MIN)) begin
            res_loss = sxl_pkg::LOSS_MIN;
            res_sat  = 1'b1;
         end else begin
            res_loss = ~quo_ff[sxl_pkg::LOSS_W-1:0] + 1'b1;
            res_sat  = 1'b0;
         end
      end else begin
         if (quo_ff > sxl_pkg::SUM_W'(sxl_pkg::LOSS_MAX)) begin
            res_loss = sxl_pkg::LOSS_MAX;
            res_sat  = 1'b1;
         end else begin
            res_loss = quo_ff[sxl_pkg::LOSS_W-1:0];
            res_sat  = 1'b0;
         end
      end

      out_free = !out_valid_ff || rsp_pop;
      q_pop    = (state_ff == ST_IDLE) && !q_empty;
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_row_loss  = out_loss_ff;
   assign rsp_saturated = out_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == ST_HOLD) && out_free)
            out_valid_ff <= 1'b1;
         else if (rsp_pop && out_valid_ff)
            out_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  num_ff   <= num_in;
                  den_ff   <= q_data.len;
                  neg_ff   <= neg_in;
                  rem_ff   <= '0;
                  quo_ff   <= '0;
                  step_ff  <= '0;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               // one quotient bit a cycle
               rem_ff  <= rem_in;
               quo_ff  <= {quo_ff[sxl_pkg::SUM_W-2:0], qbit};
               num_ff  <= {num_ff[sxl_pkg::SUM_W-2:0], 1'b0};
               step_ff <= step_ff + 1'b1;
               if (step_ff == sxl_pkg::STEP_W'(sxl_pkg::DIV_STEPS - 1))
                  state_ff <= ST_HOLD;
            end
            ST_HOLD: begin
               if (out_free) begin
                  out_loss_ff  <= res_loss;
                  out_sat_ff   <= res_sat;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ===== sv/sigmoid_xent_loss_rows_core.sv =====
// the last item of a row shows its loss after passing the front register, row queue and divider
// throughput: one item a cycle while req_full is low; the bit-serial divider takes one row at
// a time behind a two-row queue, so short rows stall the input only when that queue is full
// reset (synchronous, active high) clears the accumulator, the element count and the row queue,
// returns the divider to idle, empties the result register and sets row_length to 1
module sigmoid_xent_loss_rows_core #(
   parameter int ROW_MAX = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic signed [sxl_pkg::LOGIT_W-1:0]  req_logit,
   input  logic [sxl_pkg::LABEL_W-1:0]         req_label,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [sxl_pkg::LOSS_W-1:0]   rsp_row_loss,
   output logic                                rsp_saturated,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sxl_pkg::LEN_W-1:0]           csr_row_length
);

   sxl_pkg::row_entry_type push_data;
   sxl_pkg::row_entry_type pop_data;
   logic                   q_push;
   logic                   q_full;
   logic                   q_pop;
   logic                   q_empty;

   sxl_front #(
      .ROW_MAX (ROW_MAX)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_logit      (req_logit),
      .req_label      (req_label),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_row_length (csr_row_length),
      .q_push         (q_push),
      .q_data         (push_data),
      .q_full         (q_full)
   );

   sxl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   sxl_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_data        (pop_data),
      .q_pop         (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_row_loss  (rsp_row_loss),
      .rsp_saturated (rsp_saturated)
   );

endmodule

// ===== sv/sxl_checker.sv =====
`include "assert_macros.svh"

module sxl_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_push,
   input logic                                req_full,
   input logic                                rsp_empty,
   input logic                                rsp_pop,
   input logic signed [sxl_pkg::LOSS_W-1:0]   rsp_row_loss,
   input logic                                rsp_saturated
);

   // nothing is held over a reset
   `SXL_ASSERT(a_reset_empties, clock, reset |=> rsp_empty && !req_full)

   // a waiting result stays put until it is taken
   `SXL_ASSERT_RST(a_rsp_hold, clock, reset, (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_row_loss) && $stable(rsp_saturated)))

   // a clipped loss sits on one of the two limits
   `SXL_ASSERT_RST(a_sat_limit, clock, reset, (!rsp_empty && rsp_saturated) |-> ((rsp_row_loss == sxl_pkg::LOSS_MAX) || (rsp_row_loss == sxl_pkg::LOSS_MIN)))

   // the input does not stall straight out of reset, since the front stage is then empty
   `SXL_ASSERT_RST(a_full_needs_item, clock, reset, req_full |-> !$past(reset))

endmodule

bind sigmoid_xent_loss_rows_core sxl_checker u_sxl_checker (
   .clock         (clock),
   .reset         (reset),
   .req_push      (req_push),
   .req_full      (req_full),
   .rsp_empty     (rsp_empty),
   .rsp_pop       (rsp_pop),
   .rsp_row_loss  (rsp_row_loss),
   .rsp_saturated (rsp_saturated)
);
